[hw/rtl/ets_pkg.sv]
// Package for the edge trigger search block: ring geometry, register codes,
// request and result types and the sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

    // Ring geometry: depth is a power of two so indices wrap for free
    localparam int RING_AW     = 11;
    localparam int RING_DEPTH  = 1 << RING_AW;
    localparam int SAMPLE_W    = 12;
    localparam int HALF_W      = 10;
    // Last step count of a search: half the ring plus one
    localparam int SEARCH_LAST = RING_DEPTH / 2 + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLING_EDGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SCREEN  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST   = 12'd2047;
    localparam logic [HALF_W-1:0]   HALF_SCREEN_RST = 10'd64;

    // Request function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [RING_AW-1:0] trigger_index;
        logic               found;
    } t_out_item;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/ets_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ets_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/edge_trigger_search.sv]
// Edge trigger search over a sample ring: top level with sequencer and
// output register. Depends on ets_pkg and ets_ram.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+---------------------------
//   in      | request   | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//   out     | result    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//   cfg     | write     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Sample writes are taken while idle and follow each other back to back.
// A search walks the ring backwards from the start index, ending early at the first
// crossing, one ring read per cycle through the single RAM read port feeding
// one shared threshold comparator; the result then waits for a free output register.
// After reset a clearing pass zeroes the whole ring; requests are stalled meanwhile,
// configuration writes are taken as ever.
// A pending result does not block sample writes; a finished search waits for it.
`timescale 1ns / 1ps
`default_nettype none

module edge_trigger_search
    import ets_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    // Result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    // Configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SAMPLE_W-1:0]  i_cfg_data
);

    t_state              r_state, n_state;
    logic [RING_AW-1:0]  r_wp, n_wp;
    logic [RING_AW-1:0]  r_cnt, n_cnt;
    logic [RING_AW-1:0]  r_addr, n_addr;
    logic [RING_AW-1:0]  r_start, n_start;
    logic                r_ge, n_ge;
    logic                r_le, n_le;
    logic [RING_AW-1:0]  r_res_idx, n_res_idx;
    logic                r_res_found, n_res_found;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_data, n_out_data;

    logic [SAMPLE_W-1:0] r_threshold;
    logic                r_falling;
    logic [HALF_W-1:0]   r_half;

    logic                w_in_acc;
    logic                w_we;
    logic [RING_AW-1:0]  w_waddr;
    logic [SAMPLE_W-1:0] w_wdata;
    logic [SAMPLE_W-1:0] w_rdata;
    logic                w_ge;
    logic                w_le;
    logic                w_hit;
    logic [RING_AW-1:0]  w_start;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_falling   <= 1'b0;
            r_half      <= HALF_SCREEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:    r_threshold <= i_cfg_data;
                CFG_FALLING_EDGE: r_falling   <= i_cfg_data[0];
                CFG_HALF_SCREEN:  r_half      <= i_cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample ring
    ets_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    // Shared comparator on the sample just read
    assign w_ge = (w_rdata >= r_threshold);
    assign w_le = (w_rdata <= r_threshold);

    // Crossing between the held current sample and its predecessor now read
    assign w_hit = (r_cnt >= RING_AW'(2)) &&
                   (r_falling ? (r_le && !w_le) : (r_ge && !w_ge));

    // Start index: newest sample minus the half screen offset, wrapped
    assign w_start = r_wp - RING_AW'(1) - RING_AW'(r_half);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_start     <= n_start;
        r_ge        <= n_ge;
        r_le        <= n_le;
        r_res_idx   <= n_res_idx;
        r_res_found <= n_res_found;
        r_out_data  <= n_out_data;
    end

    // Sequencer: clear, idle, walk the ring, hand over the result
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_start     = r_start;
        n_ge        = r_ge;
        n_le        = r_le;
        n_res_idx   = r_res_idx;
        n_res_found = r_res_found;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = r_wp;
        w_wdata     = i_in_data.sample;

        unique case (r_state)
            S_CLEAR: begin
                // Zero one entry a cycle
                w_we    = 1'b1;
                w_waddr = r_cnt;
                w_wdata = '0;
                n_cnt   = r_cnt + RING_AW'(1);
                if (r_cnt == RING_AW'(RING_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.func == FUNC_WRITE) begin
                        // Store the sample and advance the write pointer
                        w_we = 1'b1;
                        n_wp = r_wp + RING_AW'(1);
                    end else begin
                        // Launch the backward walk
                        n_addr  = w_start;
                        n_start = w_start;
                        n_cnt   = '0;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // Step one position back; the sample read becomes the current one
                n_addr = r_addr - RING_AW'(1);
                n_cnt  = r_cnt + RING_AW'(1);
                n_ge   = w_ge;
                n_le   = w_le;
                if (w_hit) begin
                    n_res_idx   = r_addr + RING_AW'(2);
                    n_res_found = 1'b1;
                    n_state     = S_DONE;
                end else if (r_cnt == RING_AW'(SEARCH_LAST)) begin
                    n_res_idx   = r_start;
                    n_res_found = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                // Load the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_data.trigger_index = r_res_idx;
                    n_out_data.found         = r_res_found;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Ring is written only by the clearing pass or a sample write
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR) || (r_state == S_IDLE))
        else $error("ring written outside clear or idle");

    // A search request starts the walk from step zero at the start index
    a_search_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.func == FUNC_SEARCH)
        |=> (r_state == S_SEARCH) && (r_cnt == '0) && (r_addr == r_start))
        else $error("search did not launch cleanly");

    // The walk never runs past its last step
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_cnt <= RING_AW'(SEARCH_LAST)))
        else $error("search step count overran");

    // A pending result is never overwritten while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_state == S_DONE) |=> (r_state == S_DONE))
        else $error("result dropped under stall");

endmodule

`default_nettype wire
